>>> design/uets_pkg.sv
// Package for the USB endpoint transfer sequencer: event codes, result codes,
// classified-event and result structs shared by front end, back end and top.
`timescale 1ns / 1ps
package uets_pkg;

    typedef enum logic [2:0] {
        MODE_START_IN  = 3'd0,
        MODE_START_OUT = 3'd1,
        MODE_ACK       = 3'd2,
        MODE_NAK       = 3'd3,
        MODE_SETUP     = 3'd4,
        MODE_SET_ADDR  = 3'd5,
        MODE_STALL     = 3'd6,
        MODE_UNUSED    = 3'd7
    } t_mode;

    localparam logic [1:0] COPY_NONE    = 2'd0;
    localparam logic [1:0] COPY_TO_FIFO = 2'd1;
    localparam logic [1:0] COPY_TO_BUF  = 2'd2;

    localparam logic [1:0] DONE_NONE  = 2'd0;
    localparam logic [1:0] DONE_IN    = 2'd1;
    localparam logic [1:0] DONE_OUT   = 2'd2;
    localparam logic [1:0] DONE_SETUP = 2'd3;

    localparam logic [2:0] CFG_IN_LIMIT   = 3'd0;
    localparam logic [2:0] CFG_OUT_LIMIT  = 3'd1;
    localparam logic [2:0] CFG_OUT_MASK   = 3'd2;
    localparam logic [2:0] CFG_NAK_WAIT   = 3'd3;
    localparam logic [2:0] CFG_NAK_GIVEUP = 3'd4;

    // Event kinds after classification by the front end.
    typedef enum logic [3:0] {
        EV_NONE,
        EV_START_IN,
        EV_START_OUT,
        EV_IN_ACK,
        EV_OUT_ACK,
        EV_NAK_OUT,
        EV_NAK_IN,
        EV_SETUP,
        EV_SET_ADDR,
        EV_STALL
    } t_ev;

    typedef struct packed {
        t_ev         ev;
        logic [2:0]  ep;
        logic [6:0]  lim;
        logic [15:0] len;
        logic [6:0]  bytes;
        logic [6:0]  addr;
    } t_cmd;

    typedef struct packed {
        logic [2:0]  event_endpoint;
        logic        arm;
        logic [6:0]  arm_length;
        logic [1:0]  copy_kind;
        logic [15:0] copy_offset;
        logic [6:0]  copy_length;
        logic [1:0]  completion;
        logic [15:0] received_total;
        logic        stall_res;
        logic        address_write;
        logic [6:0]  new_address;
    } t_res;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_WRITE,
        ST_EMIT
    } t_state;

endpackage

>>> design/uets_front.sv
// Front end: holds configuration, classifies endpoint events into commands
// and selects the packet limit. Depends on uets_pkg.
`timescale 1ns / 1ps
module uets_front
    import uets_pkg::*;
#(
    parameter int ENDPOINT_COUNT  = 7,
    parameter int EP0_PACKET_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_endpoint,
    input  logic        i_ep0_out_token,
    input  logic [15:0] i_transfer_length,
    input  logic [6:0]  i_packet_bytes,
    input  logic [6:0]  i_device_address,
    output t_cmd        o_cmd,
    output logic [3:0]  o_nak_wait,
    output logic [3:0]  o_nak_giveup
);
    logic [6:0] r_in_lim, r_out_lim, r_mask;
    logic [3:0] r_wait, r_giveup;
    logic       ep_ok, is_out, use_out;
    logic [6:0] raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_lim <= 7'd64;
            r_out_lim <= 7'd64;
            r_mask <= '0;
            r_wait <= 4'd2;
            r_giveup <= 4'd10;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IN_LIMIT:   r_in_lim <= i_cfg_data;
                CFG_OUT_LIMIT:  r_out_lim <= i_cfg_data;
                CFG_OUT_MASK:   r_mask <= i_cfg_data;
                CFG_NAK_WAIT:   r_wait <= i_cfg_data[3:0];
                CFG_NAK_GIVEUP: r_giveup <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_nak_wait = r_wait;
    assign o_nak_giveup = r_giveup;

    always_comb begin
        ep_ok = (32'(i_endpoint) < ENDPOINT_COUNT);
        is_out = (i_endpoint != 3'd7) && r_mask[i_endpoint];
        o_cmd.ep = i_endpoint;
        o_cmd.len = i_transfer_length;
        o_cmd.bytes = i_packet_bytes;
        o_cmd.addr = i_device_address;
        o_cmd.ev = EV_NONE;
        use_out = 1'b0;
        case (t_mode'(i_mode))
            MODE_START_IN:  if (ep_ok) o_cmd.ev = EV_START_IN;
            MODE_START_OUT: if (ep_ok) begin
                o_cmd.ev = EV_START_OUT;
                use_out = 1'b1;
            end
            MODE_ACK: if (ep_ok) begin
                use_out = (i_endpoint == 3'd0) ? i_ep0_out_token : is_out;
                o_cmd.ev = use_out ? EV_OUT_ACK : EV_IN_ACK;
            end
            MODE_NAK: if (ep_ok && i_endpoint != 3'd0)
                o_cmd.ev = is_out ? EV_NAK_OUT : EV_NAK_IN;
            MODE_SETUP:    begin o_cmd.ev = EV_SETUP; o_cmd.ep = '0; end
            MODE_SET_ADDR: begin o_cmd.ev = EV_SET_ADDR; o_cmd.ep = '0; end
            MODE_STALL:    begin o_cmd.ev = EV_STALL; o_cmd.ep = '0; end
            default: ;
        endcase
        raw = use_out ? r_out_lim : r_in_lim;
        if (i_endpoint == 3'd0) o_cmd.lim = 7'(EP0_PACKET_SIZE);
        else if (raw == 7'd0) o_cmd.lim = 7'd1;
        else if (raw > 7'd64) o_cmd.lim = 7'd64;
        else o_cmd.lim = raw;
    end
endmodule

>>> design/uets_back.sv
// Back end: per-endpoint transfer state and the sequencer that carries out
// one command, including a bit-serial packet-count divider. Uses uets_pkg.
`timescale 1ns / 1ps
module uets_back
    import uets_pkg::*;
#(
    parameter int ENDPOINT_COUNT = 7
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    output logic       o_cmd_ready,
    input  t_cmd       i_cmd,
    input  logic [3:0] i_nak_wait,
    input  logic [3:0] i_nak_giveup,
    output logic       o_res_valid,
    input  logic       i_res_ready,
    output t_res       o_res
);
    localparam int EW = $clog2(ENDPOINT_COUNT);

    logic [15:0] r_tx_size [ENDPOINT_COUNT];
    logic [15:0] r_tx_sent [ENDPOINT_COUNT];
    logic [6:0]  r_tx_last [ENDPOINT_COUNT];
    logic [15:0] r_tx_off  [ENDPOINT_COUNT];
    logic [15:0] r_rx_rem  [ENDPOINT_COUNT];
    logic [15:0] r_rx_recv [ENDPOINT_COUNT];
    logic [15:0] r_rx_pk   [ENDPOINT_COUNT];
    logic [15:0] r_rx_off  [ENDPOINT_COUNT];
    logic [3:0]  r_nak     [ENDPOINT_COUNT];
    logic [6:0]  r_pend;

    t_state r_state, n_state;
    t_cmd   r_cmd;
    t_res   r_res, n_res;
    logic [EW-1:0] r_ix;
    logic [15:0] r_size, r_sent, r_toff, r_rem, r_recv, r_pk, r_roff;
    logic [6:0]  r_last;
    logic [3:0]  r_nk;
    // Divider: quotient in r_q, partial remainder r_dr, dividend bits r_dd.
    logic [16:0] r_dd;
    logic [15:0] r_q;
    logic [6:0]  r_dr;
    logic [4:0]  r_cnt;

    // Values computed from the latched entry for the write step.
    logic [15:0] sent_n, avail, rem_n, recv_n, pk_n, roff_n, toff_n;
    logic [6:0]  n_in, n_rx, first_n;
    logic [7:0]  trial;

    always_comb begin
        sent_n = r_sent + 16'(r_last);
        avail = (sent_n < r_size) ? r_size - sent_n : 16'd0;
        n_in = (avail > 16'(r_cmd.lim)) ? r_cmd.lim : avail[6:0];
        toff_n = r_toff + 16'(r_last);
        n_rx = (r_cmd.bytes > r_cmd.lim) ? r_cmd.lim : r_cmd.bytes;
        if (16'(n_rx) > r_rem) n_rx = r_rem[6:0];
        rem_n = r_rem - 16'(n_rx);
        roff_n = r_roff + 16'(n_rx);
        recv_n = r_recv + 16'(n_rx);
        pk_n = (r_pk != 16'd0) ? r_pk - 16'd1 : 16'd0;
        first_n = (r_cmd.len > 16'(r_cmd.lim)) ? r_cmd.lim : r_cmd.len[6:0];
        trial = {r_dr, r_dd[16]} - {1'b0, r_cmd.lim};
    end

    // Result of the command, taken into r_res at the write step.
    always_comb begin
        n_res = '0;
        n_res.event_endpoint = r_cmd.ep;
        case (r_cmd.ev)
            EV_START_IN: begin
                n_res.arm = 1'b1;
                n_res.arm_length = first_n;
                n_res.copy_kind = COPY_TO_FIFO;
                n_res.copy_length = first_n;
            end
            EV_START_OUT: n_res.arm = 1'b1;
            EV_IN_ACK: begin
                if (r_ix == '0 && r_pend != 7'd0) begin
                    n_res.address_write = 1'b1;
                    n_res.new_address = r_pend;
                    n_res.stall_res = 1'b1;
                end
                if (avail != 16'd0) begin
                    n_res.arm = 1'b1;
                    n_res.arm_length = n_in;
                    n_res.copy_kind = COPY_TO_FIFO;
                    n_res.copy_offset = toff_n;
                    n_res.copy_length = n_in;
                end else begin
                    n_res.completion = DONE_IN;
                end
            end
            EV_OUT_ACK: begin
                if (n_rx != 7'd0) begin
                    n_res.copy_kind = COPY_TO_BUF;
                    n_res.copy_offset = r_roff;
                    n_res.copy_length = n_rx;
                end
                if (n_rx < r_cmd.lim || pk_n == 16'd0) n_res.completion = DONE_OUT;
                else n_res.arm = 1'b1;
                n_res.received_total = recv_n;
            end
            EV_NAK_OUT: n_res.arm = 1'b1;
            EV_NAK_IN: if (r_nk != 4'd0) begin
                if (r_nk > i_nak_giveup) n_res.completion = DONE_IN;
                else if (r_nk > i_nak_wait) n_res.arm = 1'b1;
            end
            EV_SETUP: n_res.completion = DONE_SETUP;
            EV_STALL: n_res.stall_res = 1'b1;
            default: ;
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_cmd_valid) n_state = ST_READ;
            ST_READ:  n_state = (r_cmd.ev == EV_START_OUT) ? ST_DIV : ST_WRITE;
            ST_DIV:   if (r_cnt == 5'd0) n_state = ST_WRITE;
            ST_WRITE: n_state = ST_EMIT;
            ST_EMIT:  if (i_res_ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    assign o_cmd_ready = (r_state == ST_IDLE);
    assign o_res_valid = (r_state == ST_EMIT);
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < ENDPOINT_COUNT; e++) begin
                r_tx_size[e] <= '0; r_tx_sent[e] <= '0; r_tx_last[e] <= '0;
                r_tx_off[e] <= '0; r_rx_rem[e] <= '0; r_rx_recv[e] <= '0;
                r_rx_pk[e] <= '0; r_rx_off[e] <= '0; r_nak[e] <= '0;
            end
            r_pend <= '0;
        end else begin
            case (r_state)
                ST_IDLE: if (i_cmd_valid) begin
                    r_cmd <= i_cmd;
                    r_ix <= EW'(i_cmd.ep);
                end
                ST_READ: begin
                    r_size <= r_tx_size[r_ix]; r_sent <= r_tx_sent[r_ix];
                    r_last <= r_tx_last[r_ix]; r_toff <= r_tx_off[r_ix];
                    r_rem <= r_rx_rem[r_ix];   r_recv <= r_rx_recv[r_ix];
                    r_pk <= r_rx_pk[r_ix];     r_roff <= r_rx_off[r_ix];
                    r_nk <= r_nak[r_ix];
                    // ceil(len / lim) as floor((len + lim - 1) / lim)
                    r_dd <= 17'(r_cmd.len) + 17'(r_cmd.lim) - 17'd1;
                    r_dr <= '0;
                    r_q <= '0;
                    r_cnt <= 5'd17;
                end
                ST_DIV: if (r_cnt != 5'd0) begin
                    if (!trial[7]) begin
                        r_dr <= trial[6:0];
                        r_q <= {r_q[14:0], 1'b1};
                    end else begin
                        r_dr <= {r_dr[5:0], r_dd[16]};
                        r_q <= {r_q[14:0], 1'b0};
                    end
                    r_dd <= {r_dd[15:0], 1'b0};
                    r_cnt <= r_cnt - 5'd1;
                end
                ST_WRITE: begin
                    r_res <= n_res;
                    case (r_cmd.ev)
                        EV_START_IN: begin
                            r_tx_size[r_ix] <= r_cmd.len;
                            r_tx_sent[r_ix] <= '0;
                            r_tx_off[r_ix] <= '0;
                            r_nak[r_ix] <= 4'd1;
                            r_tx_last[r_ix] <= first_n;
                        end
                        EV_START_OUT: begin
                            r_rx_rem[r_ix] <= r_cmd.len;
                            r_rx_pk[r_ix] <= (r_cmd.len == 16'd0) ? 16'd1 : r_q;
                            r_rx_recv[r_ix] <= '0;
                            r_rx_off[r_ix] <= '0;
                        end
                        EV_IN_ACK: begin
                            if (r_ix != '0) r_nak[r_ix] <= '0;
                            else if (r_pend != 7'd0) r_pend <= '0;
                            r_tx_sent[r_ix] <= sent_n;
                            if (avail != 16'd0) begin
                                r_tx_off[r_ix] <= toff_n;
                                r_tx_last[r_ix] <= n_in;
                            end else begin
                                r_tx_last[r_ix] <= '0;
                            end
                        end
                        EV_OUT_ACK: begin
                            if (r_ix != '0) r_nak[r_ix] <= '0;
                            r_rx_rem[r_ix] <= rem_n;
                            r_rx_off[r_ix] <= roff_n;
                            r_rx_recv[r_ix] <= recv_n;
                            r_rx_pk[r_ix] <= pk_n;
                        end
                        EV_NAK_IN: if (r_nk != 4'd0) begin
                            if (r_nk > i_nak_giveup) r_nak[r_ix] <= '0;
                            else if (r_nk != 4'd15) r_nak[r_ix] <= r_nk + 4'd1;
                        end
                        EV_SETUP: begin
                            r_tx_size[0] <= '0; r_tx_sent[0] <= '0;
                            r_tx_last[0] <= '0; r_rx_rem[0] <= '0;
                            r_rx_recv[0] <= '0; r_rx_pk[0] <= '0;
                        end
                        EV_SET_ADDR: r_pend <= r_cmd.addr;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end
endmodule

>>> design/usb_endpoint_transfer_sequencer.sv
// Top level of the USB endpoint transfer sequencer: front end, a two-entry
// command queue, and back end with a result register. Depends on uets_pkg.
//
// Channel | Direction | Handshake               | Payload
// event   | in        | push / full             | mode, endpoint, token, lengths, address
// result  | out       | empty / pop             | eleven result fields
// config  | in        | i_cfg_valid/o_cfg_ready | index, data
//
// In the back end an event passes through take, read entry, write and show,
// and a start OUT event also passes through the bit-serial packet-count
// divide. Reset is synchronous and clears all endpoint state, the pending
// address and the queue. The front end classifies events into a two-entry
// queue, so a new event beat is taken while the back end works or while its
// result waits for a pop; the block stalls on push only when that queue is full.
`timescale 1ns / 1ps
module usb_endpoint_transfer_sequencer
    import uets_pkg::*;
#(
    parameter int ENDPOINT_COUNT  = 7,
    parameter int EP0_PACKET_SIZE = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_mode,
    input  logic [2:0]  i_endpoint,
    input  logic        i_ep0_out_token,
    input  logic [15:0] i_transfer_length,
    input  logic [6:0]  i_packet_bytes,
    input  logic [6:0]  i_device_address,
    output logic        empty,
    input  logic        pop,
    output logic [2:0]  o_event_endpoint,
    output logic        o_arm,
    output logic [6:0]  o_arm_length,
    output logic [1:0]  o_copy_kind,
    output logic [15:0] o_copy_offset,
    output logic [6:0]  o_copy_length,
    output logic [1:0]  o_completion,
    output logic [15:0] o_received_total,
    output logic        o_stall_res,
    output logic        o_address_write,
    output logic [6:0]  o_new_address,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data
);
    t_cmd       front_cmd;
    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic [3:0] nak_wait, nak_giveup;
    logic       back_ready, res_valid;
    t_res       res;
    logic       do_push, do_take;

    // Configuration is taken whenever the block is out of reset; the user
    // only writes while idle.
    assign o_cfg_ready = i_rst_n;

    uets_front #(
        .ENDPOINT_COUNT (ENDPOINT_COUNT),
        .EP0_PACKET_SIZE(EP0_PACKET_SIZE)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_mode           (i_mode),
        .i_endpoint       (i_endpoint),
        .i_ep0_out_token  (i_ep0_out_token),
        .i_transfer_length(i_transfer_length),
        .i_packet_bytes   (i_packet_bytes),
        .i_device_address (i_device_address),
        .o_cmd            (front_cmd),
        .o_nak_wait       (nak_wait),
        .o_nak_giveup     (nak_giveup)
    );

    // Two-entry command queue between front and back.
    assign full = (r_cnt == 2'd2);
    assign do_push = push && !full;
    assign do_take = back_ready && (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_q[r_wp] <= front_cmd;
    end

    uets_back #(
        .ENDPOINT_COUNT(ENDPOINT_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (r_cnt != 2'd0),
        .o_cmd_ready (back_ready),
        .i_cmd       (r_q[r_rp]),
        .i_nak_wait  (nak_wait),
        .i_nak_giveup(nak_giveup),
        .o_res_valid (res_valid),
        .i_res_ready (pop),
        .o_res       (res)
    );

    assign empty = !res_valid;
    assign o_event_endpoint = res.event_endpoint;
    assign o_arm = res.arm;
    assign o_arm_length = res.arm_length;
    assign o_copy_kind = res.copy_kind;
    assign o_copy_offset = res.copy_offset;
    assign o_copy_length = res.copy_length;
    assign o_completion = res.completion;
    assign o_received_total = res.received_total;
    assign o_stall_res = res.stall_res;
    assign o_address_write = res.address_write;
    assign o_new_address = res.new_address;
endmodule

>>> design/uets_checker.sv
// Port-level checker for the USB endpoint transfer sequencer and its bind.
// Depends on uets_pkg for result codes.
`timescale 1ns / 1ps
module uets_port_props
    import uets_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        empty,
    input logic        pop,
    input logic        o_arm,
    input logic [6:0]  o_arm_length,
    input logic [1:0]  o_copy_kind,
    input logic [6:0]  o_copy_length,
    input logic [1:0]  o_completion,
    input logic        o_address_write,
    input logic        o_stall_res
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty) else $error("result dropped");
    a_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_arm_length <= 7'd64 && o_copy_length <= 7'd64)
        else $error("length above 64");
    a_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_address_write) |-> o_stall_res)
        else $error("address without stall");
    a_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_completion != DONE_NONE) |-> !o_arm)
        else $error("arm with completion");
    a_copy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_copy_kind == COPY_NONE) |-> o_copy_length == 7'd0)
        else $error("length without copy");
endmodule

bind usb_endpoint_transfer_sequencer uets_port_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .empty(empty), .pop(pop), .o_arm(o_arm),
    .o_arm_length(o_arm_length), .o_copy_kind(o_copy_kind),
    .o_copy_length(o_copy_length), .o_completion(o_completion),
    .o_address_write(o_address_write), .o_stall_res(o_stall_res)
);
